[design/dwm_pkg.sv]
// Shared constants, control struct and helper for the domain wildcard matcher.
// No dependencies; every other design file imports this package.
`default_nettype none

package dwm_pkg;

  // Table geometry
  localparam int NUM_ENTRIES = 8;
  localparam int PATTERN_MAX = 64;
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);

  // Fixed field widths
  localparam int CMD_W   = 2;
  localparam int ENTRY_W = 3;
  localparam int CHAR_W  = 8;

  // Commands
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  // Special characters
  localparam logic [CHAR_W-1:0] CHAR_STAR = 8'h2A;
  localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;

  // Per-entry control broadcast from the input stage
  typedef struct packed {
    logic              clr;    // clear this entry
    logic              app;    // append a pattern byte to this entry
    logic              qry;    // query name byte
    logic              first;  // first byte of a name
    logic              step;   // byte takes part in the compare
    logic              last;   // last byte of pattern or name
    logic [CHAR_W-1:0] fc;     // case-folded byte
  } dwm_ctrl_t;

  // ASCII upper case to lower case
  function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/domain_wildcard_matcher.sv]
// Top level of the domain wildcard matcher: input register, entry array, result stage.
// Depends on dwm_pkg, dwm_entry and dwm_result.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in      | input     | in_valid_i/in_ready_o | command_i entry_i char_byte_i is_last_i
//  out     | output    | out_valid_o/out_ready_i | hit_o hit_entry_o
//
// One transfer per cycle in sustained operation, while no output stall holds a last name
// byte. A result is shown the cycle after its query byte leaves the input register.
// The per-entry shift-and update sets the critical path.
// Reset clears all entries at once; no sweep is needed after reset.
// A stall on the output only holds the input register when it carries a last name byte.
`default_nettype none

module domain_wildcard_matcher (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dwm_pkg::CMD_W-1:0]   command_i,
  input  logic [dwm_pkg::ENTRY_W-1:0] entry_i,
  input  logic [dwm_pkg::CHAR_W-1:0]  char_byte_i,
  input  logic                        is_last_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        hit_o,
  output logic [dwm_pkg::ENTRY_W-1:0] hit_entry_o
);
  import dwm_pkg::*;

  // Input register
  logic               in_valid_q;
  logic [CMD_W-1:0]   cmd_q;
  logic [ENTRY_W-1:0] ent_q;
  logic [CHAR_W-1:0]  char_q;
  logic               last_q;

  // Name in progress: at least one byte of the current name seen
  logic               in_name_q, in_name_d;

  logic               res_item;   // item that produces a result
  logic               go;         // input register item is executed this cycle
  logic               in_fire;
  logic [CHAR_W-1:0]  fc;

  dwm_ctrl_t             ctrl [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] match;

  assign res_item   = in_valid_q && (cmd_q == CMD_QUERY) && last_q;
  assign go         = in_valid_q && (!res_item || !out_valid_o || out_ready_i);
  assign in_ready_o = !in_valid_q || go;
  assign in_fire    = in_valid_i && in_ready_o;
  assign fc         = fold(char_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= command_i;
      ent_q  <= entry_i;
      char_q <= char_byte_i;
      last_q <= is_last_i;
    end
  end

  // Name tracking; a last query byte ends the name
  always_comb begin
    in_name_d = in_name_q;
    if (go && cmd_q == CMD_QUERY) begin
      in_name_d = !last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_name_q <= 1'b0;
    end else begin
      in_name_q <= in_name_d;
    end
  end

  // Entry array: clear/append address one entry, query bytes go to all of them.
  // A trailing dot after earlier name bytes is not compared.
  for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_entry
    logic sel;
    assign sel = (int'(ent_q) == g);

    always_comb begin
      ctrl[g].clr   = go && (cmd_q == CMD_CLEAR) && sel;
      ctrl[g].app   = go && (cmd_q == CMD_APPEND) && sel;
      ctrl[g].qry   = go && (cmd_q == CMD_QUERY);
      ctrl[g].first = !in_name_q;
      ctrl[g].step  = !(last_q && (fc == CHAR_DOT) && in_name_q);
      ctrl[g].last  = last_q;
      ctrl[g].fc    = fc;
    end

    dwm_entry u_entry (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl[g]),
      .match_o (match[g])
    );
  end

  dwm_result u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (go && res_item),
    .match_i     (match),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .hit_o       (hit_o),
    .hit_entry_o (hit_entry_o)
  );

`ifndef NO_ASSERTIONS
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && res_item |=> out_valid_o)
    else $error("result not presented after last name byte");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) |-> $past(go && res_item))
    else $error("result appeared without a last name byte");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !go |=> in_valid_q && $stable(cmd_q) && $stable(last_q))
    else $error("stalled input register item lost");

  a_name_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && res_item |=> !in_name_q)
    else $error("name state not cleared after last byte");
`endif

endmodule

`default_nettype wire

[design/dwm_entry.sv]
// One pattern table entry: byte storage, pattern decode and shift-and matcher.
// Depends on dwm_pkg.
`default_nettype none

module dwm_entry (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dwm_pkg::dwm_ctrl_t ctrl_i,
  output logic              match_o
);
  import dwm_pkg::*;

  localparam logic [2:0] FORM_EXACT    = 3'd0;
  localparam logic [2:0] FORM_PREFIX   = 3'd1;
  localparam logic [2:0] FORM_SUFFIX   = 3'd2;
  localparam logic [2:0] FORM_CONTAINS = 3'd3;
  localparam logic [2:0] FORM_ALL      = 3'd4;

  logic [CHAR_W-1:0]      bytes_q [PATTERN_MAX];
  logic [CHAR_W-1:0]      prev_q;
  logic [LEN_W-1:0]       len_q, len_d;
  logic                   done_q, done_d;
  logic                   over_q, over_d;
  logic                   valid_q, valid_d;
  logic                   armed_q, armed_d;
  logic [2:0]             form_q, form_d;
  logic                   start_q, start_d;
  logic [PATTERN_MAX-1:0] endm_q, endm_d;
  logic [PATTERN_MAX-1:0] w_q, w_d;
  logic                   v0_q, v0_d;
  logic                   seen_q, seen_d;

  // Append / finish decode
  logic                   wr;
  logic                   dot;
  logic                   ws, we, all_f;
  logic [LEN_W-1:0]       flen, clen, cend;
  logic [CHAR_W-1:0]      p0, lastb;
  logic [2:0]             form_new;
  logic [PATTERN_MAX-1:0] endm_new;

  always_comb begin
    wr    = ctrl_i.app && !done_q && (len_q < LEN_W'(PATTERN_MAX));
    flen  = len_q + LEN_W'(1);
    dot   = (flen > LEN_W'(1)) && (ctrl_i.fc == CHAR_DOT);
    clen  = dot ? (flen - LEN_W'(1)) : flen;
    lastb = dot ? prev_q : ctrl_i.fc;
    p0    = (len_q == '0) ? ctrl_i.fc : bytes_q[0];
    ws    = (p0 == CHAR_STAR);
    we    = 1'b0;
    all_f = 1'b0;
    cend  = clen;
    if (ws && clen == LEN_W'(1)) begin
      all_f = 1'b1;
    end else if (lastb == CHAR_STAR && (clen - LEN_W'(ws)) == LEN_W'(1)) begin
      all_f = 1'b1;
    end else if (lastb == CHAR_STAR) begin
      we   = 1'b1;
      cend = clen - LEN_W'(1);
    end
    if (all_f) begin
      form_new = FORM_ALL;
    end else if (ws) begin
      form_new = we ? FORM_CONTAINS : FORM_SUFFIX;
    end else begin
      form_new = we ? FORM_PREFIX : FORM_EXACT;
    end
    for (int j = 0; j < PATTERN_MAX; j++) begin
      endm_new[j] = (LEN_W'(j + 1) == cend);
    end
  end

  // Query: shift-and update over the stored positions
  logic                   armed_n, v0_old, seen_old, active, end_hit;
  logic [PATTERN_MAX-1:0] w_old, chain, w_upd;

  always_comb begin
    armed_n  = ctrl_i.first ? valid_q : armed_q;
    v0_old   = ctrl_i.first ? 1'b1 : v0_q;
    seen_old = ctrl_i.first ? 1'b0 : seen_q;
    w_old    = ctrl_i.first ? '0 : w_q;
    active   = armed_n && (form_q != FORM_ALL) && ctrl_i.step;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      chain[j] = v0_old && (start_q ? (j == 1) : (j == 0));
      if (j > 0) begin
        chain[j] = chain[j] | w_old[j-1];
      end
      w_upd[j] = chain[j] && (bytes_q[j] == ctrl_i.fc);
    end
    end_hit = |(w_upd & endm_q);
  end

  // Next state
  always_comb begin
    len_d   = len_q;
    done_d  = done_q;
    over_d  = over_q;
    valid_d = valid_q;
    armed_d = armed_q;
    form_d  = form_q;
    start_d = start_q;
    endm_d  = endm_q;
    w_d     = w_q;
    v0_d    = v0_q;
    seen_d  = seen_q;
    if (ctrl_i.clr) begin
      len_d   = '0;
      done_d  = 1'b0;
      over_d  = 1'b0;
      valid_d = 1'b0;
      armed_d = 1'b0;
      form_d  = FORM_EXACT;
      start_d = 1'b0;
      endm_d  = '0;
      w_d     = '0;
      v0_d    = 1'b0;
      seen_d  = 1'b0;
    end else if (ctrl_i.app && !done_q) begin
      if (wr) begin
        len_d = flen;
      end else begin
        over_d = 1'b1;
      end
      if (ctrl_i.last) begin
        done_d = 1'b1;
        if (wr && !over_q) begin
          valid_d = 1'b1;
          form_d  = form_new;
          start_d = ws && !all_f;
          endm_d  = endm_new;
        end
      end
    end else if (ctrl_i.qry) begin
      armed_d = armed_n;
      if (active) begin
        w_d    = w_upd;
        v0_d   = (form_q == FORM_SUFFIX) || (form_q == FORM_CONTAINS);
        seen_d = seen_old | end_hit;
      end else begin
        w_d    = w_old;
        v0_d   = v0_old;
        seen_d = seen_old;
      end
    end
  end

  always_comb begin
    case (form_q)
      FORM_ALL:                match_o = armed_d;
      FORM_EXACT, FORM_SUFFIX: match_o = armed_d && |(w_d & endm_q);
      default:                 match_o = armed_d && seen_d;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      done_q  <= 1'b0;
      over_q  <= 1'b0;
      valid_q <= 1'b0;
      armed_q <= 1'b0;
      form_q  <= FORM_EXACT;
      start_q <= 1'b0;
      endm_q  <= '0;
      w_q     <= '0;
      v0_q    <= 1'b0;
      seen_q  <= 1'b0;
    end else begin
      len_q   <= len_d;
      done_q  <= done_d;
      over_q  <= over_d;
      valid_q <= valid_d;
      armed_q <= armed_d;
      form_q  <= form_d;
      start_q <= start_d;
      endm_q  <= endm_d;
      w_q     <= w_d;
      v0_q    <= v0_d;
      seen_q  <= seen_d;
    end
  end

  // Pattern bytes: no reset, only positions below the length are used
  always_ff @(posedge clk_i) begin
    if (wr) begin
      prev_q <= ctrl_i.fc;
      for (int j = 0; j < PATTERN_MAX; j++) begin
        if (len_q == LEN_W'(j)) begin
          bytes_q[j] <= ctrl_i.fc;
        end
      end
    end
  end

endmodule

`default_nettype wire

[design/dwm_result.sv]
// Lowest-index hit selection and the result output register.
// Depends on dwm_pkg.
`default_nettype none

module dwm_result (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  logic [dwm_pkg::NUM_ENTRIES-1:0] match_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic                        hit_o,
  output logic [dwm_pkg::ENTRY_W-1:0] hit_entry_o
);
  import dwm_pkg::*;

  logic               valid_q, valid_d;
  logic               hit_q;
  logic [ENTRY_W-1:0] idx_q;
  logic               hit_c;
  logic [ENTRY_W-1:0] idx_c;

  always_comb begin
    hit_c = 1'b0;
    idx_c = '0;
    for (int e = NUM_ENTRIES - 1; e >= 0; e--) begin
      if (match_i[e]) begin
        hit_c = 1'b1;
        idx_c = ENTRY_W'(e);
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      hit_q <= hit_c;
      idx_q <= idx_c;
    end
  end

  assign out_valid_o = valid_q;
  assign hit_o       = hit_q;
  assign hit_entry_o = idx_q;

endmodule

`default_nettype wire
